// ===== rtl/ihx_pkg.sv =====
// Shared types and constants for the IPv4/L4 header extractor.
`timescale 1ns / 1ps

package ihx_pkg;

    // Frame layout (byte offsets from the start of the Ethernet frame)
    localparam int ETH_HDR_LEN    = 14;
    localparam int POS_IHL        = 14;
    localparam int POS_IDENT_HI   = 18;
    localparam int POS_IDENT_LO   = 19;
    localparam int POS_TTL        = 22;
    localparam int POS_PROTO      = 23;
    localparam int POS_SRC_FIRST  = 26;
    localparam int POS_SRC_LAST   = 29;
    localparam int POS_DST_FIRST  = 30;
    localparam int POS_DST_LAST   = 33;
    localparam int MIN_IP_FRAME   = 34;

    // Offsets inside the transport header
    localparam int L4_SPORT_HI    = 0;
    localparam int L4_SPORT_LO    = 1;
    localparam int L4_DPORT_HI    = 2;
    localparam int L4_DPORT_LO    = 3;
    localparam int L4_UDP_SUM_HI  = 6;
    localparam int L4_UDP_SUM_LO  = 7;
    localparam int L4_TCP_FLAGS   = 13;
    localparam int L4_TCP_SUM_HI  = 16;
    localparam int L4_TCP_SUM_LO  = 17;
    localparam int TCP_HDR_LEN    = 20;
    localparam int UDP_HDR_LEN    = 8;

    // IP protocol numbers
    localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
    localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
    localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;

    // Protocol class codes
    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_TCP   = 2'd1;
    localparam logic [1:0] CLS_UDP   = 2'd2;
    localparam logic [1:0] CLS_ICMP  = 2'd3;

    localparam int CAP_LEN_W   = 17;
    localparam int OUT_TDATA_W = 200;
    localparam int OUT_FIELD_W = 195;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } ihx_byte_t;

    typedef struct packed {
        logic [31:0]          packet_number;
        logic [1:0]           protocol_class;
        logic [31:0]          src_address;
        logic [31:0]          dst_address;
        logic [7:0]           time_to_live;
        logic [15:0]          ip_ident;
        logic [15:0]          l4_sport;
        logic [15:0]          l4_dport;
        logic [7:0]           tcp_flag_bits;
        logic [15:0]          l4_checksum;
        logic [CAP_LEN_W-1:0] captured_length;
    } ihx_rec_t;

endpackage

// ===== rtl/ipv4_l4_header_extractor_core.sv =====
// Top level of the IPv4/L4 header extractor.
`timescale 1ns / 1ps

// Takes a captured Ethernet frame one byte per request on the slave stream
// (tlast on the final byte) and returns one header record per frame on the
// master stream. IPv4 is assumed to start at byte 14 (EtherType is not
// checked); the TCP/UDP header is taken at 14 + IHL*4. IP fields are zero
// for frames under 34 bytes; ports, flags and checksum are zero unless the
// whole TCP (20 byte) or UDP (8 byte) header was captured. Bytes beyond
// MAX_LEN are dropped but the frame still closes on tlast; captured_length
// holds the low 17 bits of the count. Throughput is one byte per clock
// while the input does not stall: each byte sits in an input register while
// the parser updates its field registers, and the final byte writes the
// record register when the parser takes it. A frame's record is valid from
// the clock edge at which the parser takes its last byte from the input
// register. The input only stalls when a record is still waiting at the
// output and another frame's last byte is ready to close.

module ipv4_l4_header_extractor_core
#(
    parameter int MAX_LEN = 65536
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side: frame bytes
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
    input  logic                               s_axis_tlast,  // last_byte
    // master side: one record per frame
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] packet_number, [33:32] protocol_class, [65:34] src_address,
    // [97:66] dst_address, [105:98] time_to_live, [121:106] ip_ident,
    // [137:122] l4_sport, [153:138] l4_dport, [161:154] tcp_flag_bits,
    // [177:162] l4_checksum, [194:178] captured_length, [199:195] zero
    output logic [ihx_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import ihx_pkg::*;

    ihx_byte_t s_byte;
    ihx_byte_t cur_byte;
    logic      byte_valid;
    logic      take;
    ihx_rec_t  rec;

    assign s_byte.data = s_axis_tdata;
    assign s_byte.last = s_axis_tlast;

    ihx_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_byte     (s_byte),
        .byte_valid (byte_valid),
        .byte_out   (cur_byte),
        .take       (take)
    );

    ihx_parser #(
        .MAX_LEN (MAX_LEN)
    ) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_in    (cur_byte),
        .take       (take),
        .rec_valid  (m_axis_tvalid),
        .rec_ready  (m_axis_tready),
        .rec        (rec)
    );

    // pack first field at the lowest bits
    assign m_axis_tdata = {
        (OUT_TDATA_W - OUT_FIELD_W)'(0),
        rec.captured_length,
        rec.l4_checksum,
        rec.tcp_flag_bits,
        rec.l4_dport,
        rec.l4_sport,
        rec.ip_ident,
        rec.time_to_live,
        rec.dst_address,
        rec.src_address,
        rec.protocol_class,
        rec.packet_number
    };

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0))
        else $error("nonzero padding in record");

    // a byte is only consumed when one is held
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> byte_valid)
        else $error("parser took a byte that was not there");

    // input stays open while no byte is held
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_valid |-> s_axis_tready)
        else $error("input stalled with empty register");

endmodule

// ===== rtl/ihx_in_stage.sv =====
// Input register stage: holds one frame byte until the parser takes it.
`timescale 1ns / 1ps

module ihx_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  ihx_pkg::ihx_byte_t s_byte,
    output logic              byte_valid,
    output ihx_pkg::ihx_byte_t byte_out,
    input  logic              take
);
    import ihx_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ihx_byte_t byte_reg;

    assign s_ready    = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_out   = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            byte_reg <= s_byte;
        end
    end

endmodule

// ===== rtl/ihx_parser.sv =====
// Per-frame field capture and result record register.
`timescale 1ns / 1ps

module ihx_parser
#(
    parameter int MAX_LEN = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  ihx_pkg::ihx_byte_t byte_in,
    output logic              take,
    output logic              rec_valid,
    input  logic              rec_ready,
    output ihx_pkg::ihx_rec_t  rec
);
    import ihx_pkg::*;

    localparam int PW = $clog2(MAX_LEN + 1);

    logic [PW-1:0] pos_reg;
    logic [5:0]    hlen_reg;
    logic [7:0]    proto_reg;
    logic [31:0]   src_addr_reg;
    logic [31:0]   dst_addr_reg;
    logic [7:0]    ttl_reg;
    logic [15:0]   ident_reg;
    logic [15:0]   sport_reg;
    logic [15:0]   dport_reg;
    logic [7:0]    flags_reg;
    logic [15:0]   tcp_sum_reg;
    logic [15:0]   udp_sum_reg;
    logic [31:0]   frame_cnt_reg;
    logic          rec_valid_reg;
    ihx_rec_t      rec_reg;

    // captured values including the current byte
    logic [PW-1:0] pos_next;
    logic [5:0]    hlen_next;
    logic [7:0]    proto_next;
    logic [31:0]   src_addr_next;
    logic [31:0]   dst_addr_next;
    logic [7:0]    ttl_next;
    logic [15:0]   ident_next;
    logic [15:0]   sport_next;
    logic [15:0]   dport_next;
    logic [7:0]    flags_next;
    logic [15:0]   tcp_sum_next;
    logic [15:0]   udp_sum_next;
    logic [31:0]   frame_cnt_next;
    logic          rec_valid_next;
    ihx_rec_t      rec_next;

    logic          counting;
    logic [PW-1:0] l4_pos;
    logic [PW-1:0] l4_rel;
    logic          in_l4;
    logic [7:0]    b;
    logic          load;

    assign b         = byte_in.data;
    assign take      = byte_valid && (!byte_in.last || !rec_valid_reg || rec_ready);
    assign load      = take && byte_in.last;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    always_comb
    begin
        counting      = pos_reg < PW'(MAX_LEN);
        hlen_next     = hlen_reg;
        proto_next    = proto_reg;
        src_addr_next = src_addr_reg;
        dst_addr_next = dst_addr_reg;
        ttl_next      = ttl_reg;
        ident_next    = ident_reg;
        sport_next    = sport_reg;
        dport_next    = dport_reg;
        flags_next    = flags_reg;
        tcp_sum_next  = tcp_sum_reg;
        udp_sum_next  = udp_sum_reg;
        pos_next      = pos_reg;

        if (counting)
        begin
            pos_next = pos_reg + PW'(1);
            case (pos_reg)
                PW'(POS_IHL):       hlen_next  = {b[3:0], 2'b00};
                PW'(POS_IDENT_HI),
                PW'(POS_IDENT_LO):  ident_next = {ident_reg[7:0], b};
                PW'(POS_TTL):       ttl_next   = b;
                PW'(POS_PROTO):     proto_next = b;
                PW'(POS_SRC_FIRST),
                PW'(POS_SRC_FIRST + 1),
                PW'(POS_SRC_FIRST + 2),
                PW'(POS_SRC_LAST):  src_addr_next = {src_addr_reg[23:0], b};
                PW'(POS_DST_FIRST),
                PW'(POS_DST_FIRST + 1),
                PW'(POS_DST_FIRST + 2),
                PW'(POS_DST_LAST):  dst_addr_next = {dst_addr_reg[23:0], b};
                default: ;
            endcase
        end

        // transport header starts after the IHL just seen, if any
        l4_pos = PW'(ETH_HDR_LEN) + PW'(hlen_next);
        in_l4  = pos_reg >= l4_pos;
        l4_rel = pos_reg - l4_pos;

        if (counting && in_l4)
        begin
            case (l4_rel)
                PW'(L4_SPORT_HI),
                PW'(L4_SPORT_LO):   sport_next   = {sport_reg[7:0], b};
                PW'(L4_DPORT_HI),
                PW'(L4_DPORT_LO):   dport_next   = {dport_reg[7:0], b};
                PW'(L4_UDP_SUM_HI),
                PW'(L4_UDP_SUM_LO): udp_sum_next = {udp_sum_reg[7:0], b};
                PW'(L4_TCP_FLAGS):  flags_next   = b;
                PW'(L4_TCP_SUM_HI),
                PW'(L4_TCP_SUM_LO): tcp_sum_next = {tcp_sum_reg[7:0], b};
                default: ;
            endcase
        end

        frame_cnt_next = frame_cnt_reg + 32'd1;

        // record, built from the values that include this byte
        rec_next                 = '0;
        rec_next.packet_number   = frame_cnt_next;
        rec_next.captured_length = CAP_LEN_W'(pos_next);
        if (pos_next >= PW'(MIN_IP_FRAME))
        begin
            rec_next.src_address  = src_addr_next;
            rec_next.dst_address  = dst_addr_next;
            rec_next.time_to_live = ttl_next;
            rec_next.ip_ident     = ident_next;
            if (proto_next == PROTO_NUM_TCP)
            begin
                rec_next.protocol_class = CLS_TCP;
                if (pos_next >= l4_pos + PW'(TCP_HDR_LEN))
                begin
                    rec_next.l4_sport      = sport_next;
                    rec_next.l4_dport      = dport_next;
                    rec_next.tcp_flag_bits = flags_next;
                    rec_next.l4_checksum   = tcp_sum_next;
                end
            end
            else if (proto_next == PROTO_NUM_UDP)
            begin
                rec_next.protocol_class = CLS_UDP;
                if (pos_next >= l4_pos + PW'(UDP_HDR_LEN))
                begin
                    rec_next.l4_sport    = sport_next;
                    rec_next.l4_dport    = dport_next;
                    rec_next.l4_checksum = udp_sum_next;
                end
            end
            else if (proto_next == PROTO_NUM_ICMP)
            begin
                rec_next.protocol_class = CLS_ICMP;
            end
        end

        rec_valid_next = load || (rec_valid_reg && !rec_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hlen_reg      <= '0;
            proto_reg     <= '0;
            src_addr_reg  <= '0;
            dst_addr_reg  <= '0;
            ttl_reg       <= '0;
            ident_reg     <= '0;
            sport_reg     <= '0;
            dport_reg     <= '0;
            flags_reg     <= '0;
            tcp_sum_reg   <= '0;
            udp_sum_reg   <= '0;
            frame_cnt_reg <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
            if (load)
            begin
                // end of frame: per-frame state starts over
                pos_reg       <= '0;
                hlen_reg      <= '0;
                proto_reg     <= '0;
                src_addr_reg  <= '0;
                dst_addr_reg  <= '0;
                ttl_reg       <= '0;
                ident_reg     <= '0;
                sport_reg     <= '0;
                dport_reg     <= '0;
                flags_reg     <= '0;
                tcp_sum_reg   <= '0;
                udp_sum_reg   <= '0;
                frame_cnt_reg <= frame_cnt_next;
            end
            else if (take)
            begin
                pos_reg      <= pos_next;
                hlen_reg     <= hlen_next;
                proto_reg    <= proto_next;
                src_addr_reg <= src_addr_next;
                dst_addr_reg <= dst_addr_next;
                ttl_reg      <= ttl_next;
                ident_reg    <= ident_next;
                sport_reg    <= sport_next;
                dport_reg    <= dport_next;
                flags_reg    <= flags_next;
                tcp_sum_reg  <= tcp_sum_next;
                udp_sum_reg  <= udp_sum_next;
            end
        end
    end

    // record payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_next;
        end
    end

    // the byte counter never passes the length limit
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_LEN))
        else $error("byte position beyond MAX_LEN");

    // a finished frame leaves the parser at the frame start
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (pos_reg == '0) && (hlen_reg == '0))
        else $error("per-frame state not cleared after last byte");

    // each record carries the next frame number
    a_frame_number: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> rec_reg.packet_number == $past(frame_cnt_reg) + 32'd1)
        else $error("packet number out of sequence");

    // TCP flags only appear on TCP records
    a_flags_tcp_only: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid_reg && (rec_reg.protocol_class != CLS_TCP))
            |-> (rec_reg.tcp_flag_bits == 8'd0))
        else $error("TCP flags on a non-TCP record");

    // a new record is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid_reg && !rec_ready) |-> !load)
        else $error("pending record overwritten");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the IPv4/L4 header extractor core.
`timescale 1ns / 1ps

module tb_top;

    import ihx_pkg::*;

    localparam int FRAME_CAP    = 65536;  // byte cap per frame, same as the DUT
    localparam int IDLE_PCT     = 13;     // idle chance per cycle on each side
    localparam int N_DIR        = 12;
    localparam int RAND_FRAMES  = 4;
    localparam int BURST_FRAMES = 10;     // short frames sent during the sink hold-off
    localparam int SINK_HOLD    = 300;    // length of the hold-off in which the sink refuses records
    localparam int DRAIN_LIMIT  = 2000;

    typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

    typedef struct {
        int         length;
        bit         shaped;   // force IHL nibble and protocol byte
        logic [3:0] ihl;
        logic [7:0] proto;
        fill_t      fill;
        bit         typed;    // want holds the expected record
        ihx_rec_t   want;
    } frame_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // header tracker state, follows every accepted byte
    logic [CAP_LEN_W-1:0] cur_pos;
    logic [5:0]           cur_hlen;
    logic [7:0]           cur_proto;
    logic [31:0]          cur_src;
    logic [31:0]          cur_dst;
    logic [7:0]           cur_ttl;
    logic [15:0]          cur_ident;
    logic [15:0]          cur_sport;
    logic [15:0]          cur_dport;
    logic [7:0]           cur_flags;
    logic [15:0]          cur_tcp_sum;
    logic [15:0]          cur_udp_sum;
    logic [31:0]          frames_seen;

    ihx_rec_t   rec_q[$];        // records owed by the DUT, oldest first
    logic [7:0] frame_bytes[];   // frame being sent
    frame_row_t dir_rows [0:N_DIR-1];

    bit steady;       // no idling on either side while set
    int hold_reqs;    // bumped to ask the sink for a hold-off
    int errors;
    int recs_checked;
    int frames_sent;
    int bytes_sent;

    ipv4_l4_header_extractor_core #(
        .MAX_LEN (FRAME_CAP)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    function automatic ihx_rec_t mk_rec(input logic [31:0] pkt, input logic [1:0] cls,
                                        input logic [31:0] sa, input logic [31:0] da,
                                        input logic [7:0] ttl, input logic [15:0] id,
                                        input logic [15:0] sp, input logic [15:0] dp,
                                        input logic [7:0] fl, input logic [15:0] cs,
                                        input logic [CAP_LEN_W-1:0] len);
        ihx_rec_t r;
        r.packet_number   = pkt;
        r.protocol_class  = cls;
        r.src_address     = sa;
        r.dst_address     = da;
        r.time_to_live    = ttl;
        r.ip_ident        = id;
        r.l4_sport        = sp;
        r.l4_dport        = dp;
        r.tcp_flag_bits   = fl;
        r.l4_checksum     = cs;
        r.captured_length = len;
        return r;
    endfunction

    task automatic clear_frame_state();
        cur_pos     = '0;
        cur_hlen    = '0;
        cur_proto   = '0;
        cur_src     = '0;
        cur_dst     = '0;
        cur_ttl     = '0;
        cur_ident   = '0;
        cur_sport   = '0;
        cur_dport   = '0;
        cur_flags   = '0;
        cur_tcp_sum = '0;
        cur_udp_sum = '0;
    endtask

    // Header tracker: one accepted byte in, a record out on the last byte.
    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output bit done, output ihx_rec_t rec);
        int l4_start;
        int off;
        done = 1'b0;
        rec  = '0;
        if (cur_pos < FRAME_CAP)
        begin
            if (cur_pos == POS_IHL)
                cur_hlen = {b[3:0], 2'b00};
            if (cur_pos == POS_IDENT_HI || cur_pos == POS_IDENT_LO)
                cur_ident = {cur_ident[7:0], b};
            if (cur_pos == POS_TTL)
                cur_ttl = b;
            if (cur_pos == POS_PROTO)
                cur_proto = b;
            if (cur_pos >= POS_SRC_FIRST && cur_pos <= POS_SRC_LAST)
                cur_src = {cur_src[23:0], b};
            if (cur_pos >= POS_DST_FIRST && cur_pos <= POS_DST_LAST)
                cur_dst = {cur_dst[23:0], b};
            // transport header start uses the IHL taken from this very byte
            l4_start = ETH_HDR_LEN + cur_hlen;
            if (cur_pos >= ETH_HDR_LEN && cur_pos >= l4_start)
            begin
                off = cur_pos - l4_start;
                case (off)
                    L4_SPORT_HI, L4_SPORT_LO:     cur_sport   = {cur_sport[7:0], b};
                    L4_DPORT_HI, L4_DPORT_LO:     cur_dport   = {cur_dport[7:0], b};
                    L4_UDP_SUM_HI, L4_UDP_SUM_LO: cur_udp_sum = {cur_udp_sum[7:0], b};
                    L4_TCP_FLAGS:                 cur_flags   = b;
                    L4_TCP_SUM_HI, L4_TCP_SUM_LO: cur_tcp_sum = {cur_tcp_sum[7:0], b};
                    default: ;
                endcase
            end
            cur_pos++;
        end
        if (last)
        begin
            frames_seen++;
            l4_start            = ETH_HDR_LEN + cur_hlen;
            rec.packet_number   = frames_seen;
            rec.captured_length = cur_pos;
            if (cur_pos >= MIN_IP_FRAME)
            begin
                rec.src_address  = cur_src;
                rec.dst_address  = cur_dst;
                rec.time_to_live = cur_ttl;
                rec.ip_ident     = cur_ident;
                case (cur_proto)
                    PROTO_NUM_TCP:
                    begin
                        rec.protocol_class = CLS_TCP;
                        if (cur_pos >= l4_start + TCP_HDR_LEN)
                        begin
                            rec.l4_sport      = cur_sport;
                            rec.l4_dport      = cur_dport;
                            rec.tcp_flag_bits = cur_flags;
                            rec.l4_checksum   = cur_tcp_sum;
                        end
                    end
                    PROTO_NUM_UDP:
                    begin
                        rec.protocol_class = CLS_UDP;
                        if (cur_pos >= l4_start + UDP_HDR_LEN)
                        begin
                            rec.l4_sport    = cur_sport;
                            rec.l4_dport    = cur_dport;
                            rec.l4_checksum = cur_udp_sum;
                        end
                    end
                    PROTO_NUM_ICMP: rec.protocol_class = CLS_ICMP;
                    default:        rec.protocol_class = CLS_OTHER;
                endcase
            end
            clear_frame_state();
            done = 1'b1;
        end
    endtask

    task automatic make_frame(input int len, input bit shaped, input logic [3:0] ihl,
                              input logic [7:0] proto, input fill_t fill);
        frame_bytes = new[len];
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO: frame_bytes[i] = 8'h00;
                FILL_ONES: frame_bytes[i] = 8'hFF;
                default:   frame_bytes[i] = 8'($urandom_range(0, 255));
            endcase
        end
        if (shaped && len > POS_IHL)
            frame_bytes[POS_IHL] = {frame_bytes[POS_IHL][7:4], ihl};
        if (shaped && len > POS_PROTO)
            frame_bytes[POS_PROTO] = proto;
    endtask

    // Sends frame_bytes; each byte starts at a falling edge, returns at the accepting
    // rising edge so the next byte's single assignment lands in a later step.
    task automatic send_frame(input bit has_typed, input ihx_rec_t typed);
        ihx_rec_t rec;
        bit       done;
        int       n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            @(negedge clk);
            while (!steady && $urandom_range(0, 99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_bytes[i];
            s_tlast  <= (i == n - 1);
            do
                @(posedge clk);
            while (!s_tready);
            parse_byte(frame_bytes[i], (i == n - 1), done, rec);
            if (done)
                rec_q.insert(rec_q.size(), has_typed ? typed : rec);
            bytes_sent++;
        end
        frames_sent++;
    endtask

    task automatic go_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Record checker: compare each accepted record with the oldest one owed.
    always @(posedge clk)
    begin : rec_check
        ihx_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rec_q.size() == 0)
                report_mismatch("record with no frame pending", 64'(m_tdata[31:0]), '0);
            else
            begin
                want = rec_q.pop_front();
                check_field("packet_number",   64'(m_tdata[31:0]),
                            64'(want.packet_number));
                check_field("protocol_class",  64'(m_tdata[33:32]),
                            64'(want.protocol_class));
                check_field("src_address",     64'(m_tdata[65:34]),
                            64'(want.src_address));
                check_field("dst_address",     64'(m_tdata[97:66]),
                            64'(want.dst_address));
                check_field("time_to_live",    64'(m_tdata[105:98]),
                            64'(want.time_to_live));
                check_field("ip_ident",        64'(m_tdata[121:106]),
                            64'(want.ip_ident));
                check_field("l4_sport",        64'(m_tdata[137:122]),
                            64'(want.l4_sport));
                check_field("l4_dport",        64'(m_tdata[153:138]),
                            64'(want.l4_dport));
                check_field("tcp_flag_bits",   64'(m_tdata[161:154]),
                            64'(want.tcp_flag_bits));
                check_field("l4_checksum",     64'(m_tdata[177:162]),
                            64'(want.l4_checksum));
                check_field("captured_length", 64'(m_tdata[194:178]),
                            64'(want.captured_length));
                check_field("tdata pad",       64'(m_tdata[199:195]), '0);
                recs_checked++;
            end
        end
    end

    // Sink side: random back-pressure, plus a long hold-off on request.
    initial
    begin : sink_drive
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != holds_seen)
            begin
                holds_seen = hold_reqs;
                hold_left  = SINK_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin
        #1_000_000;
        $display("TIMEOUT: stream did not complete");
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int         kind;
        int         len;
        int         need;
        logic [3:0] ihl;
        logic [7:0] proto;
        int         drain;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        rst_n        = 1'b0;
        steady       = 1'b0;
        hold_reqs    = 0;
        errors       = 0;
        recs_checked = 0;
        frames_sent  = 0;
        bytes_sent   = 0;
        frames_seen  = '0;
        clear_frame_state();

        // directed frames; typed records where the answer is obvious
        dir_rows[0]  = '{1, 1'b0, 4'd0, 8'd0, FILL_ZERO, 1'b1,
                         mk_rec(1, CLS_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 1)};
        dir_rows[1]  = '{33, 1'b0, 4'd0, 8'd0, FILL_ONES, 1'b1,
                         mk_rec(2, CLS_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 33)};
        dir_rows[2]  = '{34, 1'b0, 4'd0, 8'd0, FILL_ONES, 1'b1,
                         mk_rec(3, CLS_OTHER, '1, '1, '1, '1, 0, 0, 0, 0, 34)};
        // TCP/UDP header exactly complete, then one byte short
        dir_rows[3]  = '{54, 1'b1, 4'd5, PROTO_NUM_TCP, FILL_RAND, 1'b0, '0};
        dir_rows[4]  = '{53, 1'b1, 4'd5, PROTO_NUM_TCP, FILL_RAND, 1'b0, '0};
        dir_rows[5]  = '{42, 1'b1, 4'd5, PROTO_NUM_UDP, FILL_RAND, 1'b0, '0};
        dir_rows[6]  = '{41, 1'b1, 4'd5, PROTO_NUM_UDP, FILL_RAND, 1'b0, '0};
        dir_rows[7]  = '{34, 1'b1, 4'd5, PROTO_NUM_ICMP, FILL_RAND, 1'b0, '0};
        // IHL under 5: transport header overlaps the IP header
        dir_rows[8]  = '{34, 1'b1, 4'd0, PROTO_NUM_TCP, FILL_RAND, 1'b0, '0};
        // largest IHL, header not reached
        dir_rows[9]  = '{34, 1'b1, 4'd15, PROTO_NUM_UDP, FILL_RAND, 1'b0, '0};
        // largest IHL, TCP header just complete
        dir_rows[10] = '{94, 1'b1, 4'd15, PROTO_NUM_TCP, FILL_ONES, 1'b1,
                         mk_rec(11, CLS_TCP, '1, '1, '1, '1, '1, '1, '1, '1, 94)};
        dir_rows[11] = '{2, 1'b0, 4'd0, 8'd0, FILL_ONES, 1'b1,
                         mk_rec(12, CLS_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 2)};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++)
        begin
            // no idling across the threshold frames
            steady = (r >= 3 && r <= 8);
            make_frame(dir_rows[r].length, dir_rows[r].shaped, dir_rows[r].ihl,
                       dir_rows[r].proto, dir_rows[r].fill);
            send_frame(dir_rows[r].typed, dir_rows[r].want);
        end
        steady = 1'b0;

        for (int f = 0; f < RAND_FRAMES; f++)
        begin
            if (f == 1)
            begin
                // sink holds off while short frames keep coming: DUT fills and stalls
                hold_reqs++;
                for (int k = 0; k < BURST_FRAMES; k++)
                begin
                    make_frame($urandom_range(1, 6), 1'b0, 4'd0, 8'd0, FILL_RAND);
                    send_frame(1'b0, '0);
                end
            end

            if (f == RAND_FRAMES - 1)
            begin
                go_quiet();
                wait (rec_q.size() == 0);
            end

            kind  = $urandom_range(0, 9);
            ihl   = ($urandom_range(0, 9) < 6) ? 4'd5 : 4'($urandom_range(0, 15));
            proto = 8'($urandom_range(0, 255));
            if (kind <= 2)
            begin
                proto = PROTO_NUM_TCP;
                need  = ETH_HDR_LEN + ihl * 4 + TCP_HDR_LEN;
            end
            else if (kind <= 5)
            begin
                proto = PROTO_NUM_UDP;
                need  = ETH_HDR_LEN + ihl * 4 + UDP_HDR_LEN;
            end
            else if (kind == 6)
            begin
                proto = PROTO_NUM_ICMP;
                need  = MIN_IP_FRAME;
            end
            else
                need = MIN_IP_FRAME;
            if (need < MIN_IP_FRAME)
                need = MIN_IP_FRAME;

            // lengths cluster around the completeness threshold
            len = need + $urandom_range(0, 15) - 3;
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, MIN_IP_FRAME - 1);

            if (kind >= 8)
                make_frame($urandom_range(1, 80), 1'b0, 4'd0, 8'd0, FILL_RAND);
            else
                make_frame(len, 1'b1, ihl, proto, FILL_RAND);
            send_frame(1'b0, '0);
        end

        steady = 1'b0;
        go_quiet();

        drain = 0;
        while (rec_q.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (rec_q.size() != 0)
            report_mismatch("records never delivered", 64'(rec_q.size()), '0);
        repeat (8) @(posedge clk);

        $display("Run: %0d frames, %0d bytes - short, truncated, TCP/UDP/ICMP/other,",
                 frames_sent, bytes_sent);
        $display("small and largest IHL, sink hold-off; %0d records checked.",
                 recs_checked);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ihx_pkg.sv
rtl/ihx_in_stage.sv
rtl/ihx_parser.sv
rtl/ipv4_l4_header_extractor_core.sv
verif/tb_top.sv
